FILE: sv/pfp_pkg.sv
package pfp_pkg;

	// Default field depth; each field keeps at most depth-1 bytes, capped at 255
	localparam int FIELD_DEPTH_DEF = 256;

	// Frame delimiters
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_SEP   = 8'h2C;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	// Event codes reported with each result
	localparam logic [2:0] EV_IGNORED = 3'd0;
	localparam logic [2:0] EV_START   = 3'd1;
	localparam logic [2:0] EV_ID      = 3'd2;
	localparam logic [2:0] EV_SEP     = 3'd3;
	localparam logic [2:0] EV_VALUE   = 3'd4;
	localparam logic [2:0] EV_DONE    = 3'd5;
	localparam logic [2:0] EV_DROPPED = 3'd6;

	typedef struct packed {
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] data_byte;
		logic [7:0] position;
		logic [7:0] id_length;
		logic [7:0] value_length;
	} res_item_t;

endpackage

FILE: sv/pfp_if.sv
interface pfp_in_if;
	logic              valid;
	logic              ready;
	pfp_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface pfp_res_if;
	logic               valid;
	logic               ready;
	pfp_pkg::res_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/pfp_core.sv
module pfp_core #(
	parameter int FIELD_DEPTH = pfp_pkg::FIELD_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	output pfp_pkg::res_item_t res
);

	// Bytes a field may hold: depth-1, kept within 1..255
	localparam int LIMIT_RAW = (FIELD_DEPTH - 1 > 255) ? 255 :
		((FIELD_DEPTH < 2) ? 1 : FIELD_DEPTH - 1);
	localparam logic [7:0] LIMIT = LIMIT_RAW[7:0];

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_ID    = 2'd1,
		MODE_VALUE = 2'd2
	} mode_t;

	mode_t      mode_q, mode_d;
	logic [7:0] id_cnt_q, id_cnt_d;
	logic [7:0] val_cnt_q, val_cnt_d;

	// Decode one byte against the current mode and field counts
	always_comb begin
		mode_d           = mode_q;
		id_cnt_d         = id_cnt_q;
		val_cnt_d        = val_cnt_q;
		res.event_res    = pfp_pkg::EV_IGNORED;
		res.data_byte    = 8'd0;
		res.position     = 8'd0;
		if (rx_byte == pfp_pkg::CH_OPEN) begin
			mode_d        = MODE_ID;
			id_cnt_d      = 8'd0;
			val_cnt_d     = 8'd0;
			res.event_res = pfp_pkg::EV_START;
		end else begin
			unique case (mode_q)
				MODE_ID: begin
					if (rx_byte == pfp_pkg::CH_SEP) begin
						mode_d        = MODE_VALUE;
						res.event_res = pfp_pkg::EV_SEP;
					end else if (id_cnt_q < LIMIT) begin
						res.event_res = pfp_pkg::EV_ID;
						res.data_byte = rx_byte;
						res.position  = id_cnt_q;
						id_cnt_d      = id_cnt_q + 8'd1;
					end else begin
						res.event_res = pfp_pkg::EV_DROPPED;
					end
				end
				MODE_VALUE: begin
					if (rx_byte == pfp_pkg::CH_CLOSE) begin
						mode_d        = MODE_IDLE;
						res.event_res = pfp_pkg::EV_DONE;
					end else if (val_cnt_q < LIMIT) begin
						res.event_res = pfp_pkg::EV_VALUE;
						res.data_byte = rx_byte;
						res.position  = val_cnt_q;
						val_cnt_d     = val_cnt_q + 8'd1;
					end else begin
						res.event_res = pfp_pkg::EV_DROPPED;
					end
				end
				default: begin
					// idle, and the unused code acts as idle
					res.event_res = pfp_pkg::EV_IGNORED;
				end
			endcase
		end
		res.id_length    = id_cnt_d;
		res.value_length = val_cnt_d;
	end

	// Advance parse state once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			id_cnt_q  <= 8'd0;
			val_cnt_q <= 8'd0;
		end else if (step) begin
			mode_q    <= mode_d;
			id_cnt_q  <= id_cnt_d;
			val_cnt_q <= val_cnt_d;
		end
	end

endmodule

FILE: sv/paren_comma_frame_parser.sv
// Frame parser for byte streams of the form '(' id ',' value ')'.
// Channel rx takes one received byte per transaction (valid/ready).
// Channel res returns exactly one result per byte: an event code, the
// byte and its position for id/value writes, and both field lengths.
// An accepted byte waits in the input register and is then decoded into
// the result register, which drives res. Throughput: one byte per cycle
// while res is not stalled, set by the combinational decode between the
// input register and the result register; no loop or memory limits it.
// A stalled receiver holds the result register; the input register still
// takes one more byte, after which rx.ready drops until res moves again.
// Reset (arst_n low) empties both registers, returns the parser to idle
// outside a frame and clears both field lengths. No setup is needed.
// An opening parenthesis restarts a frame at any time; bytes beyond the
// field capacity (FIELD_DEPTH-1, at most 255) are dropped and flagged.
module paren_comma_frame_parser #(
	parameter int FIELD_DEPTH = pfp_pkg::FIELD_DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	pfp_in_if.sink   rx,
	pfp_res_if.source res
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               res_valid_q;
	pfp_pkg::res_item_t res_q;
	pfp_pkg::res_item_t decode;
	logic               advance;

	// Move stage 1 into the result register when it is free or being drained
	assign advance  = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	// Hold the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.payload.rx_byte;
		end
	end

	pfp_core #(
		.FIELD_DEPTH(FIELD_DEPTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.rx_byte(byte_s1),
		.res    (decode)
	);

	// Register the result; hold it while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || res.ready) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= decode;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

`ifndef NO_ASSERTIONS
	// A full pipeline with a stalled receiver must refuse new bytes
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && !res.ready |-> !rx.ready)
		else $error("input accepted while pipeline is full");

	// Only id and value writes carry a byte and a position
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !(res_q.event_res == pfp_pkg::EV_ID ||
			res_q.event_res == pfp_pkg::EV_VALUE)
		|-> res_q.data_byte == 8'd0 && res_q.position == 8'd0)
		else $error("stray data on non-write event");

	// Every accepted byte lands in stage 1
	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rx.valid && rx.ready |=> valid_s1)
		else $error("accepted byte lost");

	// A processed byte always produces a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result missing after decode");
`endif

endmodule
